// ----- src/dlms_pkg.sv -----
// Shared types and codes for the DFA longest-match scanner.
`timescale 1ns / 1ps
`default_nettype none

package dlms_pkg;

  // Item action codes
  typedef enum logic [1:0] {
    ACT_WR_TRANS = 2'd0,
    ACT_WR_ACC   = 2'd1,
    ACT_SCAN     = 2'd2
  } action_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRANS,
    ST_ACC,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] state_index;
    logic [7:0] byte_value;
    logic [7:0] target_state;
    logic       target_valid;
    logic       accept_flag;
    logic       last_in_string;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] match_length;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic tt_wr;   // write transition entry
    logic acc_wr;  // write accept flag
    logic launch;  // capture scan byte, read transition entry
    logic step;    // follow transition, read accept flag
    logic check;   // record accepted prefix
    logic emit;    // load result register, rearm scan
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_in_string;
    logic out_full;
  } dpath_status_t;

endpackage

`default_nettype wire

// ----- src/dlms_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface dlms_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/dfa_longest_match_scanner_top.sv -----
// Top level of the table-driven DFA longest-match scanner.
//
// Usage: items arrive on in_i (valid/ready). Action 0 writes one transition
// entry (state_index, byte_value -> target_state, target_valid); action 1
// writes the accept flag of state_index; action 2 scans byte_value. A scan
// with last_in_string set yields one transaction on out_o carrying matched
// and match_length, after which the scan rearms from start_state.
// Other actions are dropped. The APB port holds start_state at address 0.
//
// Timing: a write leaves ready high, so writes can follow back to back. A
// scan byte runs through transition memory read, accept memory read and
// record, in that order; ready stays low after the byte is taken until the
// record step is done. The final byte adds an emit step, with ready still
// low, that loads the result register and raises out_o.valid; this step
// waits while out_o stalls. The two memory reads of each byte are
// registered, one after the other.
// Reset clears the start state to 0 and the scan state; table contents stay
// undefined until written. If out_o stalls, the result register holds; the
// next item is still taken, and only a second final byte waits for it.
`timescale 1ns / 1ps
`default_nettype none

module dfa_longest_match_scanner_top
  import dlms_pkg::*;
#(
  parameter int unsigned STATE_COUNT       = 256,
  parameter int unsigned MAX_STRING_LENGTH = 65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dlms_stream_if.sink      in_i,
  dlms_stream_if.source    out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  ctrl_cmd_t     cmd;
  dpath_status_t status;
  logic [7:0]    start_state;
  in_item_t      in_item;
  out_item_t     out_item;

  assign in_item    = in_i.data;
  assign out_o.data = out_item;

  // Configuration register
  dlms_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start_state_o (start_state)
  );

  // Sequencer: one transaction in flight at a time
  dlms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_item.action),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  // Tables, scan state and result register
  dlms_dpath #(
    .STATE_COUNT       (STATE_COUNT),
    .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .item_i        (in_item),
    .start_state_i (start_state),
    .out_ready_i   (out_o.ready),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .out_item_o    (out_item)
  );

endmodule

`default_nettype wire

// ----- src/dlms_cfg.sv -----
// APB-style configuration register file holding the start state.
`timescale 1ns / 1ps
`default_nettype none

module dlms_cfg
  import dlms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  start_state_o
);

  localparam logic REG_START_STATE = 1'b0;

  logic [7:0] start_state_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_START_STATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= 8'd0;
    end else if (wr_en) begin
      start_state_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_START_STATE) begin
      prdata = {24'd0, start_state_q};
    end
  end

  assign start_state_o = start_state_q;

endmodule

`default_nettype wire

// ----- src/dlms_ctrl.sv -----
// Controller state machine sequencing table writes and byte scans.
`timescale 1ns / 1ps
`default_nettype none

module dlms_ctrl
  import dlms_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_action_i,
  input  wire dpath_status_t status_i,
  output logic               in_ready_o,
  output ctrl_cmd_t          cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_action_i == ACT_SCAN)) begin
          state_d = ST_TRANS;
        end
      end
      ST_TRANS: state_d = ST_ACC;
      ST_ACC:   state_d = status_i.last_in_string ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (action_e'(in_action_i))
            ACT_WR_TRANS: cmd_o.tt_wr  = 1'b1;
            ACT_WR_ACC:   cmd_o.acc_wr = 1'b1;
            ACT_SCAN:     cmd_o.launch = 1'b1;
            default:      cmd_o = '0;
          endcase
        end
      end
      ST_TRANS: cmd_o.step  = 1'b1;
      ST_ACC:   cmd_o.check = 1'b1;
      ST_EMIT:  cmd_o.emit  = !status_i.out_full;
      default:  cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/dlms_dpath.sv -----
// Datapath: transition and accept memories, scan registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module dlms_dpath
  import dlms_pkg::*;
#(
  parameter int unsigned STATE_COUNT       = 256,
  parameter int unsigned MAX_STRING_LENGTH = 65535
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  input  wire in_item_t  item_i,
  input  wire logic [7:0] start_state_i,
  input  wire logic      out_ready_i,
  output dpath_status_t  status_o,
  output logic           out_valid_o,
  output out_item_t      out_item_o
);

  // Only states reachable by an 8-bit index get table rows.
  localparam int unsigned TblStates = (STATE_COUNT < 256) ? STATE_COUNT : 256;
  localparam int unsigned SidxW     = $clog2(TblStates);
  localparam int unsigned TtDepth   = TblStates * 256;
  localparam int unsigned TtAw      = SidxW + 8;
  localparam logic [15:0] PosLimit  =
    (MAX_STRING_LENGTH < 32'd65535) ? 16'(MAX_STRING_LENGTH) : 16'hFFFF;

  logic [8:0] tt_mem  [TtDepth];
  logic       acc_mem [TblStates];

  logic [8:0]  tt_rd_q;
  logic        acc_rd_q;
  logic        last_q, skip_q, from_oor_q, hit_q, tgt_oor_q;
  logic [7:0]  cur_q;
  logic [15:0] pos_q, best_q;
  logic        found_q, dead_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  logic [7:0]      from_state;
  logic            sidx_ok;
  logic [TtAw-1:0] tt_waddr, tt_raddr;

  assign from_state = (pos_q == 16'd0) ? start_state_i : cur_q;
  assign sidx_ok    = 32'(item_i.state_index) < STATE_COUNT;
  assign tt_waddr   = {item_i.state_index[SidxW-1:0], item_i.byte_value};
  assign tt_raddr   = {from_state[SidxW-1:0], item_i.byte_value};

  // Transition memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.tt_wr && sidx_ok) begin
      tt_mem[tt_waddr] <= {item_i.target_valid, item_i.target_state};
    end
    if (cmd_i.launch) begin
      tt_rd_q <= tt_mem[tt_raddr];
    end
  end

  // Accept flag memory, read at the state just reached
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_wr && sidx_ok) begin
      acc_mem[item_i.state_index[SidxW-1:0]] <= item_i.accept_flag;
    end
    if (cmd_i.step) begin
      acc_rd_q <= acc_mem[tt_rd_q[SidxW-1:0]];
    end
  end

  // Per-byte scratch registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.launch) begin
      last_q     <= item_i.last_in_string;
      skip_q     <= dead_q || (pos_q >= PosLimit);
      from_oor_q <= 32'(from_state) >= STATE_COUNT;
    end
    if (cmd_i.step) begin
      hit_q     <= !skip_q && !from_oor_q && tt_rd_q[8];
      tgt_oor_q <= 32'(tt_rd_q[7:0]) >= STATE_COUNT;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= 8'd0;
      pos_q   <= 16'd0;
      best_q  <= 16'd0;
      found_q <= 1'b0;
      dead_q  <= 1'b0;
    end else if (cmd_i.emit) begin
      cur_q   <= start_state_i;
      pos_q   <= 16'd0;
      best_q  <= 16'd0;
      found_q <= 1'b0;
      dead_q  <= 1'b0;
    end else if (cmd_i.step && !skip_q) begin
      pos_q <= pos_q + 16'd1;
      if (from_oor_q || !tt_rd_q[8]) begin
        dead_q <= 1'b1;
      end else begin
        cur_q <= tt_rd_q[7:0];
      end
    end else if (cmd_i.check && hit_q && acc_rd_q && !tgt_oor_q) begin
      found_q <= 1'b1;
      best_q  <= pos_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_q.matched      <= found_q;
      out_item_q.match_length <= found_q ? best_q : 16'd0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_item_o              = out_item_q;
  assign status_o.last_in_string = last_q;
  assign status_o.out_full       = out_valid_q && !out_ready_i;

  a_found_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (best_q != 16'd0))
    else $error("match recorded with zero length");

  a_best_le_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= pos_q)
    else $error("best length beyond scan position");

  a_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> ((pos_q == 16'd0) && !found_q && !dead_q && out_valid_q))
    else $error("scan not rearmed after result");

endmodule

`default_nettype wire
